### rtl/rlfe_pkg.sv
// Shared types, constants and the control store for the RGB fade envelope.
package rlfe_pkg;

   // Control store addressing
   localparam int unsigned UPC_W = 5;
   typedef logic [UPC_W-1:0] upc_type;

   // Total length reloaded when a fade runs out
   localparam logic [14:0] DEFAULT_TOTAL = 15'd10;

   typedef enum logic [1:0] {
      PH_DISABLED   = 2'd0,
      PH_INCREASING = 2'd1,
      PH_MAXIMUM    = 2'd2,
      PH_DECREASING = 2'd3
   } phase_type;

   // Datapath operation selected by one control word
   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_IDLE,
      UOP_SETUP,
      UOP_MUL,
      UOP_DIV,
      UOP_STORE,
      UOP_COMMIT,
      UOP_START,
      UOP_CLEAR,
      UOP_EMIT
   } uop_type;

   // Branch condition of one control word
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_ACCEPT,
      COND_IS_START,
      COND_EXPIRED,
      COND_TRIVIAL,
      COND_OUT_FREE
   } cond_type;

   // One control word: branch to target when cond holds, else stay (hold) or step on
   typedef struct packed {
      uop_type  uop;
      logic [1:0] chan;
      cond_type cond;
      logic     hold;
      upc_type  target;
   } ucode_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic accept;
      logic is_start;
      logic expired;
      logic trivial;
      logic out_free;
   } seq_status_type;

   // Program layout
   localparam upc_type A_IDLE   = 5'd0;
   localparam upc_type A_DECODE = 5'd1;
   localparam upc_type A_CHECK  = 5'd2;
   localparam upc_type A_SETUP  = 5'd3;
   localparam upc_type A_COMMIT = 5'd22;
   localparam upc_type A_START  = 5'd23;
   localparam upc_type A_CLEAR  = 5'd24;
   localparam upc_type A_EMIT   = 5'd25;

   function automatic ucode_type mk_word(uop_type uop, logic [1:0] chan, cond_type cond,
                                         logic hold, upc_type target);
      ucode_type w;
      w.uop    = uop;
      w.chan   = chan;
      w.cond   = cond;
      w.hold   = hold;
      w.target = target;
      return w;
   endfunction

   // Microprogram: decode, per-channel multiply / 4 radix-4 divide steps / store, commit
   function automatic ucode_type ucode_rom(upc_type addr);
      ucode_type w;
      unique case (addr)
         5'd0:  w = mk_word(UOP_IDLE,   2'd0, COND_ACCEPT,   1'b1, A_DECODE);
         5'd1:  w = mk_word(UOP_NOP,    2'd0, COND_IS_START, 1'b0, A_START);
         5'd2:  w = mk_word(UOP_NOP,    2'd0, COND_EXPIRED,  1'b0, A_CLEAR);
         5'd3:  w = mk_word(UOP_SETUP,  2'd0, COND_TRIVIAL,  1'b0, A_COMMIT);
         // red
         5'd4:  w = mk_word(UOP_MUL,    2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd5:  w = mk_word(UOP_DIV,    2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd6:  w = mk_word(UOP_DIV,    2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd7:  w = mk_word(UOP_DIV,    2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd8:  w = mk_word(UOP_DIV,    2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd9:  w = mk_word(UOP_STORE,  2'd0, COND_NEXT,     1'b0, A_IDLE);
         // green
         5'd10: w = mk_word(UOP_MUL,    2'd1, COND_NEXT,     1'b0, A_IDLE);
         5'd11: w = mk_word(UOP_DIV,    2'd1, COND_NEXT,     1'b0, A_IDLE);
         5'd12: w = mk_word(UOP_DIV,    2'd1, COND_NEXT,     1'b0, A_IDLE);
         5'd13: w = mk_word(UOP_DIV,    2'd1, COND_NEXT,     1'b0, A_IDLE);
         5'd14: w = mk_word(UOP_DIV,    2'd1, COND_NEXT,     1'b0, A_IDLE);
         5'd15: w = mk_word(UOP_STORE,  2'd1, COND_NEXT,     1'b0, A_IDLE);
         // blue
         5'd16: w = mk_word(UOP_MUL,    2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd17: w = mk_word(UOP_DIV,    2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd18: w = mk_word(UOP_DIV,    2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd19: w = mk_word(UOP_DIV,    2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd20: w = mk_word(UOP_DIV,    2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd21: w = mk_word(UOP_STORE,  2'd2, COND_NEXT,     1'b0, A_IDLE);
         5'd22: w = mk_word(UOP_COMMIT, 2'd0, COND_ALWAYS,   1'b0, A_EMIT);
         5'd23: w = mk_word(UOP_START,  2'd0, COND_ALWAYS,   1'b0, A_EMIT);
         5'd24: w = mk_word(UOP_CLEAR,  2'd0, COND_NEXT,     1'b0, A_IDLE);
         5'd25: w = mk_word(UOP_EMIT,   2'd0, COND_OUT_FREE, 1'b1, A_IDLE);
         default: w = mk_word(UOP_NOP,  2'd0, COND_ALWAYS,   1'b0, A_IDLE);
      endcase
      return w;
   endfunction

endpackage

### rtl/rlfe_seq.sv
// Microprogram sequencer: step counter, control store and branch logic.
module rlfe_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  rlfe_pkg::seq_status_type   status,
   output rlfe_pkg::ucode_type        ctl
);
   import rlfe_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    cond_true;

   // current control word
   assign ctl = ucode_rom(upc_ff);

   // branch condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEXT:     cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_ACCEPT:   cond_true = status.accept;
         COND_IS_START: cond_true = status.is_start;
         COND_EXPIRED:  cond_true = status.expired;
         COND_TRIVIAL:  cond_true = status.trivial;
         COND_OUT_FREE: cond_true = status.out_free;
         default:       cond_true = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (cond_true) begin
         upc_in = ctl.target;
      end else if (ctl.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= A_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

### rtl/rgb_light_fade_envelope_core.sv
// RGB fade envelope: top level with the microcoded datapath.
//
// Usage: each beat on the req_ channel is either a start (req_operation high),
// which loads target color, rise and total frame counts and the shadow flag and
// captures the color now shown as the start color, or a frame tick, which
// computes the color for the current frame and advances the frame counter.
// Every request beat yields exactly one rsp_ beat with the color, the phase and
// the shadow flag after that beat's update.
// A start beat goes straight to its response; a tick that runs out the fade
// clears to the dark state instead, and a tick at an end point of a ramp skips
// the divide. An interpolating tick uses the shared multiply / divide datapath,
// which works one channel after the other (one multiply step, four radix-4
// divide steps, one store step per channel). One request is processed at a
// time; req_ready is high only while the sequencer waits at its idle step, so
// the next beat is taken only after the last one has left its output step.
// A finished response sits in an output register; if the receiver
// stalls, the next request is still accepted and computed, and the sequencer
// then waits at its output step until the register frees up.
// Reset (synchronous) returns to the dark, disabled state with total 10.
module rgb_light_fade_envelope_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_target_red,
   input  logic [7:0]  req_target_green,
   input  logic [7:0]  req_target_blue,
   input  logic [14:0] req_rise_frames,
   input  logic [14:0] req_total_frames,
   input  logic        req_shadow_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_level,
   output logic [7:0]  rsp_green_level,
   output logic [7:0]  rsp_blue_level,
   output logic [1:0]  rsp_phase,
   output logic        rsp_shadow_mark
);
   import rlfe_pkg::*;

   ucode_type      ctl;
   seq_status_type status;

   // envelope state
   logic [15:0] cnt_ff,    cnt_in;
   logic [14:0] rise_ff,   rise_in;
   logic [14:0] total_ff,  total_in;
   logic [7:0]  start_ff [3];
   logic [7:0]  start_in [3];
   logic [7:0]  tgt_ff   [3];
   logic [7:0]  tgt_in   [3];
   logic [7:0]  cur_ff   [3];
   logic [7:0]  cur_in   [3];
   phase_type   phase_ff,  phase_in;
   logic        shadow_ff, shadow_in;

   // captured request beat
   logic        item_op_ff,  item_op_in;
   logic [7:0]  item_tgt_ff [3];
   logic [7:0]  item_tgt_in [3];
   logic [14:0] item_rise_ff,  item_rise_in;
   logic [14:0] item_total_ff, item_total_in;
   logic        item_shadow_ff, item_shadow_in;

   // per-tick setup
   logic        up_ff,       up_in;
   logic [14:0] n_ff,        n_in;
   logic [14:0] len_ff,      len_in;
   logic        triv_ff,     triv_in;
   logic        triv_tgt_ff, triv_tgt_in;
   phase_type   phase_new_ff, phase_new_in;

   // multiply / divide datapath
   logic [22:0] rem_ff,  rem_in;
   logic [22:0] dvs_ff,  dvs_in;
   logic [7:0]  quo_ff,  quo_in;
   logic        desc_ff, desc_in;
   logic [7:0]  base_ff, base_in;
   logic [7:0]  res_ff [3];
   logic [7:0]  res_in [3];

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_lvl_ff [3];
   logic [7:0]  rsp_lvl_in [3];
   phase_type   rsp_phase_ff, rsp_phase_in;
   logic        rsp_shadow_ff, rsp_shadow_in;

   // combinational helpers
   logic        cnt_lt_rise;
   logic        cnt_eq_rise;
   logic        cnt_eq_total;
   logic [7:0]  op_a;
   logic [7:0]  op_b;
   logic [7:0]  op_diff;
   logic [22:0] mul_prod;
   logic [22:0] dvs_half;
   logic [22:0] rem_mid;
   logic        q_hi;
   logic        q_lo;
   logic [22:0] rem_lo;

   rlfe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // handshake and status to the sequencer
   assign req_ready    = (ctl.uop == UOP_IDLE);
   assign cnt_lt_rise  = (cnt_ff < {1'b0, rise_ff});
   assign cnt_eq_rise  = (cnt_ff == {1'b0, rise_ff});
   assign cnt_eq_total = (cnt_ff == {1'b0, total_ff});

   assign status.accept   = req_valid && req_ready;
   assign status.is_start = item_op_ff;
   assign status.expired  = (cnt_ff > {1'b0, total_ff});
   assign status.trivial  = !cnt_lt_rise && (cnt_eq_rise || cnt_eq_total);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // ramp end points for the selected channel
   assign op_a     = up_ff ? start_ff[ctl.chan] : tgt_ff[ctl.chan];
   assign op_b     = up_ff ? tgt_ff[ctl.chan]   : 8'd0;
   assign op_diff  = (op_b < op_a) ? (op_a - op_b) : (op_b - op_a);
   assign mul_prod = {8'd0, n_ff} * {15'd0, op_diff};

   // two restoring divide steps per cycle
   assign dvs_half = dvs_ff >> 1;
   assign q_hi     = (rem_ff >= dvs_ff);
   assign rem_mid  = q_hi ? (rem_ff - dvs_ff) : rem_ff;
   assign q_lo     = (rem_mid >= dvs_half);
   assign rem_lo   = q_lo ? (rem_mid - dvs_half) : rem_mid;

   // datapath next state
   always_comb begin
      cnt_in         = cnt_ff;
      rise_in        = rise_ff;
      total_in       = total_ff;
      phase_in       = phase_ff;
      shadow_in      = shadow_ff;
      item_op_in     = item_op_ff;
      item_rise_in   = item_rise_ff;
      item_total_in  = item_total_ff;
      item_shadow_in = item_shadow_ff;
      up_in          = up_ff;
      n_in           = n_ff;
      len_in         = len_ff;
      triv_in        = triv_ff;
      triv_tgt_in    = triv_tgt_ff;
      phase_new_in   = phase_new_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quo_in         = quo_ff;
      desc_in        = desc_ff;
      base_in        = base_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_shadow_in  = rsp_shadow_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < 3; i++) begin
         start_in[i]    = start_ff[i];
         tgt_in[i]      = tgt_ff[i];
         cur_in[i]      = cur_ff[i];
         item_tgt_in[i] = item_tgt_ff[i];
         res_in[i]      = res_ff[i];
         rsp_lvl_in[i]  = rsp_lvl_ff[i];
      end

      unique case (ctl.uop)
         UOP_IDLE: begin
            // capture the request beat
            if (req_valid) begin
               item_op_in     = req_operation;
               item_tgt_in[0] = req_target_red;
               item_tgt_in[1] = req_target_green;
               item_tgt_in[2] = req_target_blue;
               item_rise_in   = req_rise_frames;
               item_total_in  = req_total_frames;
               item_shadow_in = req_shadow_request;
            end
         end
         UOP_SETUP: begin
            // pick the segment; counter is within total here
            up_in       = cnt_lt_rise;
            n_in        = cnt_lt_rise ? cnt_ff[14:0] : (cnt_ff[14:0] - rise_ff);
            len_in      = cnt_lt_rise ? rise_ff : (total_ff - rise_ff);
            triv_in     = status.trivial;
            triv_tgt_in = cnt_eq_rise;
            if (cnt_lt_rise) begin
               phase_new_in = PH_INCREASING;
            end else if (cnt_eq_rise) begin
               phase_new_in = PH_MAXIMUM;
            end else begin
               phase_new_in = PH_DECREASING;
            end
         end
         UOP_MUL: begin
            // numerator, biased by len-1 on a falling ramp for the ceiling
            desc_in = (op_b < op_a);
            base_in = op_a;
            rem_in  = (op_b < op_a) ? (mul_prod + {8'd0, len_ff - 15'd1}) : mul_prod;
            dvs_in  = {1'b0, len_ff, 7'd0};
            quo_in  = 8'd0;
         end
         UOP_DIV: begin
            rem_in = rem_lo;
            dvs_in = dvs_ff >> 2;
            quo_in = {quo_ff[5:0], q_hi, q_lo};
         end
         UOP_STORE: begin
            res_in[ctl.chan] = desc_ff ? (base_ff - quo_ff) : (base_ff + quo_ff);
         end
         UOP_COMMIT: begin
            for (int i = 0; i < 3; i++) begin
               if (triv_ff) begin
                  cur_in[i] = triv_tgt_ff ? tgt_ff[i] : 8'd0;
               end else begin
                  cur_in[i] = res_ff[i];
               end
            end
            phase_in = phase_new_ff;
            cnt_in   = cnt_ff + 16'd1;
         end
         UOP_START: begin
            for (int i = 0; i < 3; i++) begin
               start_in[i] = cur_ff[i];
               tgt_in[i]   = item_tgt_ff[i];
            end
            cnt_in    = 16'd0;
            rise_in   = item_rise_ff;
            total_in  = item_total_ff;
            shadow_in = item_shadow_ff;
         end
         UOP_CLEAR: begin
            // fade ran out: go dark and reload defaults
            for (int i = 0; i < 3; i++) begin
               start_in[i] = 8'd0;
               tgt_in[i]   = 8'd0;
               cur_in[i]   = 8'd0;
            end
            cnt_in    = 16'd0;
            rise_in   = 15'd0;
            total_in  = DEFAULT_TOTAL;
            phase_in  = PH_DISABLED;
            shadow_in = 1'b0;
         end
         UOP_EMIT: begin
            if (status.out_free) begin
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  rsp_lvl_in[i] = cur_ff[i];
               end
               rsp_phase_in  = phase_ff;
               rsp_shadow_in = shadow_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 16'd0;
         rise_ff      <= 15'd0;
         total_ff     <= DEFAULT_TOTAL;
         phase_ff     <= PH_DISABLED;
         shadow_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= 8'd0;
            tgt_ff[i]   <= 8'd0;
            cur_ff[i]   <= 8'd0;
         end
      end else begin
         cnt_ff       <= cnt_in;
         rise_ff      <= rise_in;
         total_ff     <= total_in;
         phase_ff     <= phase_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= start_in[i];
            tgt_ff[i]   <= tgt_in[i];
            cur_ff[i]   <= cur_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_op_ff     <= item_op_in;
      item_rise_ff   <= item_rise_in;
      item_total_ff  <= item_total_in;
      item_shadow_ff <= item_shadow_in;
      up_ff          <= up_in;
      n_ff           <= n_in;
      len_ff         <= len_in;
      triv_ff        <= triv_in;
      triv_tgt_ff    <= triv_tgt_in;
      phase_new_ff   <= phase_new_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      quo_ff         <= quo_in;
      desc_ff        <= desc_in;
      base_ff        <= base_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_shadow_ff  <= rsp_shadow_in;
      for (int i = 0; i < 3; i++) begin
         item_tgt_ff[i] <= item_tgt_in[i];
         res_ff[i]      <= res_in[i];
         rsp_lvl_ff[i]  <= rsp_lvl_in[i];
      end
   end

   // response ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = rsp_lvl_ff[0];
   assign rsp_green_level = rsp_lvl_ff[1];
   assign rsp_blue_level  = rsp_lvl_ff[2];
   assign rsp_phase       = 2'(rsp_phase_ff);
   assign rsp_shadow_mark = rsp_shadow_ff;

endmodule

### rtl/rlfe_checker.sv
// Port-level checks for the RGB fade envelope, bound to the top level.
module rlfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic [7:0]  req_target_red,
   input logic [7:0]  req_target_green,
   input logic [7:0]  req_target_blue,
   input logic [14:0] req_rise_frames,
   input logic [14:0] req_total_frames,
   input logic        req_shadow_request,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red_level,
   input logic [7:0]  rsp_green_level,
   input logic [7:0]  rsp_blue_level,
   input logic [1:0]  rsp_phase,
   input logic        rsp_shadow_mark
);
   import rlfe_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_level)
         && $stable(rsp_green_level) && $stable(rsp_blue_level)
         && $stable(rsp_phase) && $stable(rsp_shadow_mark))
      else $error("response beat changed while stalled");

   // disabled phase always shows a dark color
   a_dark_when_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == 2'(PH_DISABLED)) |->
         (rsp_red_level == 8'd0) && (rsp_green_level == 8'd0) && (rsp_blue_level == 8'd0))
      else $error("disabled phase with nonzero color");

   // one request at a time: no back-to-back acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // reset leaves the block idle and empty
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind rgb_light_fade_envelope_core rlfe_checker u_rlfe_checker (.*);
